@@ hdl/fgsa_pkg.sv @@
// Shared types and codes for the fence-gated slot allocator.
package fgsa_pkg;

    // Command codes carried in the input tuser field.
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_MARK    = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
    localparam logic [1:0] STATUS_REMARKED  = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    // Field widths of one transaction.
    localparam int SLOT_FIELD_W  = 6;
    localparam int FENCE_W       = 64;
    localparam int STATUS_W      = 2;
    localparam int IN_TDATA_W    = 136;
    localparam int OUT_TDATA_W   = 16;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_CMP  = 3'b100
    } state_t;

endpackage

@@ hdl/fence_gated_slot_allocator.sv @@
// An acquire examines slots from the cursor onward: a free slot is granted in the look step, a busy
// slot takes a look and a compare step; a mark takes a look and a compare step, a mark of a missing
// slot only the look step. One item is handled at a time: the next one is accepted
// once the previous result has been taken. One release-value memory read port and one
// 64-bit fence comparator are stepped over the slots.
// Reset (rst_n low, asynchronous) clears all busy marks, the cursor and the handshake state.
module fence_gated_slot_allocator #(
    parameter int SLOT_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] slot_index, [69:6] release_value, [133:70] completed_value, [135:134] zero
    input  logic [fgsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] granted, [6:1] granted_slot, [8:7] status, [15:9] zero
    output logic [fgsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SW    = fgsa_pkg::SLOT_FIELD_W;
    localparam int FW    = fgsa_pkg::FENCE_W;

    // Sequencer and latched command.
    fgsa_pkg::state_t state_reg, state_next;
    logic             cmd_reg;
    logic [SW-1:0]    sel_reg;
    logic [FW-1:0]    rel_reg;
    logic [FW-1:0]    done_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [SLOT_COUNT-1:0] busy_reg, busy_next;

    // Release-value memory; busy marks act as its valid bits.
    logic [FW-1:0] release_mem [SLOT_COUNT];
    logic [FW-1:0] rd_data_reg;
    logic          mem_we;

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    logic                          granted_reg, granted_next;
    logic [SW-1:0]                 gslot_reg, gslot_next;
    logic [fgsa_pkg::STATUS_W-1:0] status_reg, status_next;

    logic in_fire;
    logic sel_in_range;
    logic idx_last;
    logic fence_done;
    logic [IDX_W-1:0] idx_wrap;

    assign s_axis_tready = (state_reg == fgsa_pkg::ST_IDLE) && !m_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, status_reg, gslot_reg, granted_reg};

    assign sel_in_range = ({1'b0, sel_reg} < (SW + 1)'(SLOT_COUNT));
    assign idx_last     = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign idx_wrap     = idx_last ? '0 : idx_reg + 1'b1;
    // The one shared comparator: has the fence reached or passed the stored release value?
    assign fence_done   = (done_reg >= rd_data_reg);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        busy_next    = busy_reg;
        mem_we       = 1'b0;
        m_valid_next = m_valid_reg;
        granted_next = granted_reg;
        gslot_next   = gslot_reg;
        status_next  = status_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            fgsa_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next   = (s_axis_tuser == fgsa_pkg::CMD_MARK) ?
                                 s_axis_tdata[IDX_W-1:0] : cursor_reg;
                    count_next = '0;
                    state_next = fgsa_pkg::ST_LOOK;
                end
            end
            fgsa_pkg::ST_LOOK:
            begin
                if (cmd_reg == fgsa_pkg::CMD_MARK)
                begin
                    if (!sel_in_range)
                    begin
                        m_valid_next = 1'b1;
                        granted_next = 1'b0;
                        gslot_next   = '0;
                        status_next  = fgsa_pkg::STATUS_NOT_FOUND;
                        state_next   = fgsa_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = fgsa_pkg::ST_CMP;
                    end
                end
                else if (!busy_reg[idx_reg])
                begin
                    // A free slot is taken without a fence check.
                    cursor_next  = idx_wrap;
                    m_valid_next = 1'b1;
                    granted_next = 1'b1;
                    gslot_next   = SW'(idx_reg);
                    status_next  = fgsa_pkg::STATUS_OK;
                    state_next   = fgsa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = fgsa_pkg::ST_CMP;
                end
            end
            fgsa_pkg::ST_CMP:
            begin
                if (cmd_reg == fgsa_pkg::CMD_MARK)
                begin
                    status_next = (busy_reg[idx_reg] && !fence_done) ?
                                  fgsa_pkg::STATUS_REMARKED : fgsa_pkg::STATUS_OK;
                    busy_next[idx_reg] = 1'b1;
                    mem_we       = 1'b1;
                    m_valid_next = 1'b1;
                    granted_next = 1'b0;
                    gslot_next   = '0;
                    state_next   = fgsa_pkg::ST_IDLE;
                end
                else if (fence_done)
                begin
                    // Busy slot whose fence completed: release and take it.
                    busy_next[idx_reg] = 1'b0;
                    cursor_next  = idx_wrap;
                    m_valid_next = 1'b1;
                    granted_next = 1'b1;
                    gslot_next   = SW'(idx_reg);
                    status_next  = fgsa_pkg::STATUS_OK;
                    state_next   = fgsa_pkg::ST_IDLE;
                end
                else if (count_reg == IDX_W'(SLOT_COUNT - 1))
                begin
                    m_valid_next = 1'b1;
                    granted_next = 1'b0;
                    gslot_next   = '0;
                    status_next  = fgsa_pkg::STATUS_NO_SLOT;
                    state_next   = fgsa_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_wrap;
                    count_next = count_reg + 1'b1;
                    state_next = fgsa_pkg::ST_LOOK;
                end
            end
            default:
            begin
                state_next = fgsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fgsa_pkg::ST_IDLE;
            cursor_reg  <= '0;
            busy_reg    <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
        end
    end

    // Payload registers: the latched transaction and the result.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= s_axis_tuser;
            sel_reg  <= s_axis_tdata[SW-1:0];
            rel_reg  <= s_axis_tdata[SW+FW-1:SW];
            done_reg <= s_axis_tdata[SW+2*FW-1:SW+FW];
        end
        granted_reg <= granted_next;
        gslot_reg   <= gslot_next;
        status_reg  <= status_next;
    end

    // Release-value memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            release_mem[idx_reg] <= rel_reg;
        end
        rd_data_reg <= release_mem[idx_reg];
    end

    // Input is taken only while no result is pending.
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input accepted while a result is pending");

    // A new result only comes out of the search or compare steps.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == fgsa_pkg::ST_LOOK)
                            || ($past(state_reg) == fgsa_pkg::ST_CMP))
        else $error("result produced outside the sequencer steps");

    // A grant always reports ok status.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && granted_reg) |-> (status_reg == fgsa_pkg::STATUS_OK))
        else $error("grant with non-ok status");

    // The search never examines more slots than the pool holds.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= IDX_W'(SLOT_COUNT - 1)))
        else $error("search count past pool size");

    // A completed mark leaves its slot busy.
    a_mark_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fgsa_pkg::ST_CMP && cmd_reg == fgsa_pkg::CMD_MARK)
        |=> busy_reg[$past(idx_reg)])
        else $error("marked slot not busy");

endmodule
